### rtl/chbq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cascaded highpass/lowpass biquad.
// No dependencies; every other file imports this package.
package chbq_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = COEF_BITS;

  localparam logic signed [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HP_ENABLE = 3'd0,
    REG_LP_ENABLE = 3'd1,
    REG_HP_B0     = 3'd2,
    REG_HP_A1     = 3'd3,
    REG_HP_A2     = 3'd4,
    REG_LP_B0     = 3'd5,
    REG_LP_A1     = 3'd6,
    REG_LP_A2     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HP,
    ST_LP,
    ST_OUT
  } ctrl_state_e;

endpackage

### rtl/chbq_if.sv
`timescale 1ns / 1ps
// Valid/ready channels: sample input, sample output and register write.
// Depends on chbq_pkg for the field widths.
interface chbq_in_if import chbq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in_block;

  modport source (output valid, sample_in, last_in_block, input ready);
  modport sink (input valid, sample_in, last_in_block, output ready);
endinterface

interface chbq_out_if import chbq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          last_out;

  modport source (output valid, sample_out, last_out, input ready);
  modport sink (input valid, sample_out, last_out, output ready);
endinterface

interface chbq_cfg_if import chbq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  reg_index;
  logic [CFG_DATA_BITS-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

### rtl/cascaded_highpass_lowpass_biquad_top.sv
`timescale 1ns / 1ps
// Top level of the cascaded highpass/lowpass biquad filter.
// Depends on chbq_pkg, the channel interfaces in chbq_if and chbq_section.

// One word is taken at a time and passes through the highpass cell and then
// the lowpass cell, each skipped when its enable is clear. A word is
// accepted, run through each enabled section in turn and then loaded into
// the output register. Each cell's single multiplier works through the
// five products one after another, followed by the rounding and saturation
// step. The output register lets a new word be accepted while the previous
// result waits to be taken.
// Coefficients and enables are written through the register channel, which
// is always ready; write them only while the filter is idle.
module cascaded_highpass_lowpass_biquad_top import chbq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  chbq_in_if.sink     samples_i,
  chbq_out_if.source  samples_o,
  chbq_cfg_if.sink    cfg_i
);

  ctrl_state_e                   state_q, state_d;
  logic                          hp_en_q, lp_en_q;
  coef_t                         hp_coef_q, lp_coef_q;
  logic signed [SAMPLE_BITS-1:0] cur_q;
  logic                          last_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_last_q;
  logic                          in_ready, in_accept, out_free, out_load;
  logic                          hp_start, lp_start, hp_done, lp_done;
  logic signed [SAMPLE_BITS-1:0] hp_y, lp_y;
  cfg_reg_e                      cfg_reg;

  assign in_accept = samples_i.valid && in_ready;
  assign out_free  = !out_valid_q || samples_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          priority if (hp_en_q) state_d = ST_HP;
          else if (lp_en_q)     state_d = ST_LP;
          else                  state_d = ST_OUT;
        end
      end
      ST_HP: begin
        if (hp_done) state_d = lp_en_q ? ST_LP : ST_OUT;
      end
      ST_LP: begin
        if (lp_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_q == ST_IDLE);
    hp_start = (state_q == ST_HP);
    lp_start = (state_q == ST_LP);
    out_load = (state_q == ST_OUT) && out_free;
  end

  chbq_section u_hp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hp_start),
    .neg_b1_i (1'b1),
    .coef_i   (hp_coef_q),
    .x_i      (cur_q),
    .done_o   (hp_done),
    .y_o      (hp_y)
  );

  chbq_section u_lp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lp_start),
    .neg_b1_i (1'b0),
    .coef_i   (lp_coef_q),
    .x_i      (cur_q),
    .done_o   (lp_done),
    .y_o      (lp_y)
  );

  assign cfg_reg = cfg_reg_e'(cfg_i.reg_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hp_en_q     <= 1'b0;
      lp_en_q     <= 1'b0;
      hp_coef_q   <= '{b0: B0_RESET, a1: '0, a2: '0};
      lp_coef_q   <= '{b0: B0_RESET, a1: '0, a2: '0};
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (samples_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        unique case (cfg_reg)
          REG_HP_ENABLE: hp_en_q      <= cfg_i.wr_data[0];
          REG_LP_ENABLE: lp_en_q      <= cfg_i.wr_data[0];
          REG_HP_B0:     hp_coef_q.b0 <= cfg_i.wr_data[COEF_BITS-1:0];
          REG_HP_A1:     hp_coef_q.a1 <= cfg_i.wr_data[COEF_BITS-1:0];
          REG_HP_A2:     hp_coef_q.a2 <= cfg_i.wr_data[COEF_BITS-1:0];
          REG_LP_B0:     lp_coef_q.b0 <= cfg_i.wr_data[COEF_BITS-1:0];
          REG_LP_A1:     lp_coef_q.a1 <= cfg_i.wr_data[COEF_BITS-1:0];
          REG_LP_A2:     lp_coef_q.a2 <= cfg_i.wr_data[COEF_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // the word in flight: take the input, then each finished section's result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_q  <= samples_i.sample_in;
      last_q <= samples_i.last_in_block;
    end else if (hp_done) begin
      cur_q <= hp_y;
    end else if (lp_done) begin
      cur_q <= lp_y;
    end
    if (out_load) begin
      out_sample_q <= cur_q;
      out_last_q   <= last_q;
    end
  end

  assign samples_i.ready      = in_ready;
  assign samples_o.valid      = out_valid_q;
  assign samples_o.sample_out = out_sample_q;
  assign samples_o.last_out   = out_last_q;
  assign cfg_i.ready          = 1'b1;

`ifndef NO_ASSERTIONS
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("output word raised outside the load state");
  a_hp_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HP) |-> hp_en_q) else $error("highpass run while disabled");
  a_hp_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hp_done |-> (state_q == ST_HP) && !lp_done)
    else $error("highpass finished outside its state");
`endif

endmodule

### rtl/chbq_section.sv
`timescale 1ns / 1ps
// One biquad cell: holds two past inputs and two past outputs and runs the
// five products through a single multiplier. Depends on chbq_pkg.
module chbq_section import chbq_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          neg_b1_i,
  input  coef_t                         coef_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic [2:0] STEP_X   = 3'd0;
  localparam logic [2:0] STEP_X1  = 3'd1;
  localparam logic [2:0] STEP_X2  = 3'd2;
  localparam logic [2:0] STEP_Y1  = 3'd3;
  localparam logic [2:0] STEP_Y2  = 3'd4;
  localparam logic [2:0] STEP_LAST = 3'd6;
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  typedef enum logic [1:0] {
    TERM_ADD,
    TERM_SUB,
    TERM_ADD2,
    TERM_SUB2
  } term_e;

  logic                          busy_q, busy_d;
  logic [2:0]                    step_q, step_d;
  logic [2:0]                    step_cur;
  logic                          run;
  logic signed [COEF_BITS-1:0]   op_a;
  logic signed [SAMPLE_BITS-1:0] op_b;
  term_e                         op_sel, op_q;
  logic signed [PROD_W-1:0]      prod_d, prod_q;
  logic signed [ACC_W-1:0]       prod_ext, term, acc_q, acc_rnd, acc_sh;
  logic signed [SAMPLE_BITS-1:0] px_q [2];
  logic signed [SAMPLE_BITS-1:0] py_q [2];
  logic                          fits;

  assign run      = busy_q | start_i;
  assign step_cur = busy_q ? step_q : STEP_X;
  assign done_o   = busy_q && (step_q == STEP_LAST);

  // operand schedule: b0*x, 2*b0*x1 (negated when neg_b1_i is set), b0*x2, a1*y1, a2*y2
  always_comb begin
    unique case (step_cur)
      STEP_X: begin
        op_a = coef_i.b0; op_b = x_i; op_sel = TERM_ADD;
      end
      STEP_X1: begin
        op_a = coef_i.b0; op_b = px_q[0]; op_sel = neg_b1_i ? TERM_SUB2 : TERM_ADD2;
      end
      STEP_X2: begin
        op_a = coef_i.b0; op_b = px_q[1]; op_sel = TERM_ADD;
      end
      STEP_Y1: begin
        op_a = coef_i.a1; op_b = py_q[0]; op_sel = TERM_SUB;
      end
      STEP_Y2: begin
        op_a = coef_i.a2; op_b = py_q[1]; op_sel = TERM_SUB;
      end
      default: begin
        op_a = coef_i.b0; op_b = x_i; op_sel = TERM_ADD;
      end
    endcase
  end

  assign prod_d   = op_a * op_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    unique case (op_q)
      TERM_ADD:  term = prod_ext;
      TERM_SUB:  term = -prod_ext;
      TERM_ADD2: term = prod_ext <<< 1;
      TERM_SUB2: term = -(prod_ext <<< 1);
      default:   term = prod_ext;
    endcase
  end

  // round half up, then saturate to the sample range
  assign acc_rnd = acc_q + HALF_LSB;
  assign acc_sh  = acc_rnd >>> COEF_FRAC_BITS;
  assign fits    = (&acc_sh[ACC_W-1:SAMPLE_BITS-1]) || !(|acc_sh[ACC_W-1:SAMPLE_BITS-1]);

  always_comb begin
    if (fits) begin
      y_o = acc_sh[SAMPLE_BITS-1:0];
    end else begin
      y_o = {acc_sh[ACC_W-1], {(SAMPLE_BITS-1){!acc_sh[ACC_W-1]}}};
    end
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q && start_i) begin
      busy_d = 1'b1;
      step_d = STEP_X1;
    end else if (busy_q) begin
      if (step_q == STEP_LAST) begin
        busy_d = 1'b0;
        step_d = STEP_X;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_X;
      px_q[0] <= '0;
      px_q[1] <= '0;
      py_q[0] <= '0;
      py_q[1] <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (done_o) begin
        px_q[1] <= px_q[0];
        px_q[0] <= x_i;
        py_q[1] <= py_q[0];
        py_q[0] <= y_o;
      end
    end
  end

  // accumulate the product registered on the previous step
  always_ff @(posedge clk_i) begin
    if (run) begin
      prod_q <= prod_d;
      op_q   <= op_sel;
      acc_q  <= (step_cur == STEP_X) ? '0 : acc_q + term;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("cell still busy after done");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= STEP_LAST) else $error("step counter out of range");
  a_hist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |=> $stable(px_q[0]) && $stable(py_q[0]))
    else $error("history changed without a finished word");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the cascaded highpass/lowpass biquad top level.
// Needs chbq_pkg, the channel interfaces in chbq_if and the filter RTL.
// A bit-exact filter predictor in this file checks every output word.
module tb;
  import chbq_pkg::*;

  localparam int SEC_HP = 0;
  localparam int SEC_LP = 1;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam int SETTLE_CYCLES = 24;
  localparam real FS = 48000.0;
  localparam real BUTTER_Q = 0.707;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          last;
  } filtered_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  chbq_in_if  samples_if ();
  chbq_out_if results_if ();
  chbq_cfg_if cfg_if ();

  cascaded_highpass_lowpass_biquad_top DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .samples_i (samples_if),
    .samples_o (results_if),
    .cfg_i     (cfg_if)
  );

  // filter shadow: enables, coefficients and the two-deep histories
  logic    hp_on;
  logic    lp_on;
  coef_t   hp_coef;
  coef_t   lp_coef;
  sample_t past_x [2][2];
  sample_t past_y [2][2];

  filtered_word_t filtered_q [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          rx_hold = 1'b0;

  int n_errors   = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_writes   = 0;
  int n_clipped  = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d words still outstanding", filtered_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    n_errors++;
  endtask

  // one direct form I section; the numerator comes from b0 alone
  function automatic sample_t run_biquad(int sec, sample_t x, coef_t c);
    longint b0;
    longint acc;
    longint y;
    b0 = c.b0;
    acc = b0 * x
        + ((sec == SEC_LP) ? 2 : -2) * b0 * past_x[sec][0]
        + b0 * past_x[sec][1]
        - longint'(c.a1) * past_y[sec][0]
        - longint'(c.a2) * past_y[sec][1];
    acc = acc + (longint'(1) <<< (COEF_FRAC_BITS - 1));
    y = acc >>> COEF_FRAC_BITS;
    if (y > SAMPLE_MAX) begin
      y = SAMPLE_MAX;
      n_clipped++;
    end else if (y < SAMPLE_MIN) begin
      y = SAMPLE_MIN;
      n_clipped++;
    end
    past_x[sec][1] = past_x[sec][0];
    past_x[sec][0] = x;
    past_y[sec][1] = past_y[sec][0];
    past_y[sec][0] = sample_t'(y);
    return sample_t'(y);
  endfunction

  function automatic filtered_word_t filter_word(sample_t x, logic last);
    filtered_word_t w;
    sample_t v;
    v = x;
    if (hp_on) v = run_biquad(SEC_HP, v, hp_coef);
    if (lp_on) v = run_biquad(SEC_LP, v, lp_coef);
    w.smp  = v;
    w.last = last;
    return w;
  endfunction

  function automatic coef_t butterworth(real fc, bit highpass);
    coef_t c;
    real w0;
    real alpha;
    real a0;
    w0 = 2.0 * 3.14159265358979 * fc / FS;
    alpha = $sin(w0) / (2.0 * BUTTER_Q);
    a0 = 1.0 + alpha;
    if (highpass) c.b0 = COEF_BITS'($rtoi((1.0 + $cos(w0)) / 2.0 / a0 * 4194304.0));
    else          c.b0 = COEF_BITS'($rtoi((1.0 - $cos(w0)) / 2.0 / a0 * 4194304.0));
    c.a1 = COEF_BITS'($rtoi(-2.0 * $cos(w0) / a0 * 4194304.0));
    c.a2 = COEF_BITS'($rtoi((1.0 - alpha) / a0 * 4194304.0));
    return c;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(8191)) - 4096);
      2: return $urandom_range(1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
      default: return sample_t'(int'($urandom_range(1_000_000)) - 500_000);
    endcase
  endfunction

  // check each word the output channel hands over; drive ready
  always @(posedge clk_i) begin
    if (results_if.valid && results_if.ready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("output word %0d with nothing expected",
                                  results_if.sample_out));
      end else begin
        filtered_word_t want;
        want = filtered_q.pop_front();
        n_checked++;
        if (results_if.sample_out !== want.smp)
          report_mismatch($sformatf("sample_out: expected %0d got %0d",
                                    want.smp, results_if.sample_out));
        if (results_if.last_out !== want.last)
          report_mismatch($sformatf("last_out: expected %0b got %0b",
                                    want.last, results_if.last_out));
      end
    end
    if (rx_hold) results_if.ready <= 1'b0;
    else         results_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_sample(sample_t x, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    samples_if.valid         <= 1'b1;
    samples_if.sample_in     <= x;
    samples_if.last_in_block <= last;
    do @(posedge clk_i); while (!samples_if.ready);
    filtered_q.push_back(filter_word(x, last));
    n_sent++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_HP_ENABLE: hp_on = data[0];
      REG_LP_ENABLE: lp_on = data[0];
      REG_HP_B0:     hp_coef.b0 = data;
      REG_HP_A1:     hp_coef.a1 = data;
      REG_HP_A2:     hp_coef.a2 = data;
      REG_LP_B0:     lp_coef.b0 = data;
      REG_LP_A1:     lp_coef.a1 = data;
      REG_LP_A2:     lp_coef.a2 = data;
      default: ;
    endcase
    n_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid, drain every outstanding word, then let the pipeline settle
  task automatic wait_idle();
    samples_if.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // enables carry junk in the upper bits; only bit 0 counts
  task automatic configure(bit hp_en, bit lp_en, coef_t hp, coef_t lp);
    logic [CFG_DATA_BITS-1:0] en_word;
    write_reg(REG_HP_B0, hp.b0);
    write_reg(REG_HP_A1, hp.a1);
    write_reg(REG_HP_A2, hp.a2);
    write_reg(REG_LP_B0, lp.b0);
    write_reg(REG_LP_A1, lp.a1);
    write_reg(REG_LP_A2, lp.a2);
    en_word = CFG_DATA_BITS'($urandom);
    en_word[0] = hp_en;
    write_reg(REG_HP_ENABLE, en_word);
    en_word = CFG_DATA_BITS'($urandom);
    en_word[0] = lp_en;
    write_reg(REG_LP_ENABLE, en_word);
  endtask

  task automatic test_bypass_extremes();
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(SAMPLE_MAX), 1'b1);
    send_sample(sample_t'(SAMPLE_MIN), 1'b0);
    send_sample(sample_t'(-1), 1'b1);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(24'h555555), 1'b0);
  endtask

  task automatic test_section_extremes();
    // highpass on its reset coefficients: hard clipping both ways
    wait_idle();
    write_reg(REG_HP_ENABLE, 24'd1);
    send_sample(sample_t'(SAMPLE_MAX), 1'b0);
    send_sample(sample_t'(SAMPLE_MIN), 1'b0);
    send_sample(sample_t'(SAMPLE_MAX), 1'b0);
    send_sample(sample_t'(SAMPLE_MIN), 1'b1);

    // lowpass alone with full-scale coefficients
    wait_idle();
    write_reg(REG_HP_ENABLE, 24'd0);
    write_reg(REG_LP_ENABLE, 24'd1);
    write_reg(REG_LP_B0, 24'h7FFFFF);
    write_reg(REG_LP_A1, 24'h800000);
    write_reg(REG_LP_A2, 24'h7FFFFF);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(SAMPLE_MAX), 1'b1);
    send_sample(sample_t'(0), 1'b0);

    // both sections, highpass at the opposite extremes
    wait_idle();
    write_reg(REG_HP_ENABLE, 24'd1);
    write_reg(REG_HP_B0, 24'h800000);
    write_reg(REG_HP_A1, 24'h7FFFFF);
    write_reg(REG_HP_A2, 24'h800000);
    send_sample(sample_t'(SAMPLE_MIN), 1'b0);
    send_sample(sample_t'(SAMPLE_MAX), 1'b0);
    send_sample(sample_t'(0), 1'b1);

    // tiny gain so that a half-LSB sum lands exactly on the rounding point
    wait_idle();
    write_reg(REG_HP_ENABLE, 24'hFFFFFE);
    write_reg(REG_LP_B0, 24'd1);
    write_reg(REG_LP_A1, 24'd0);
    write_reg(REG_LP_A2, 24'd0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(2097152), 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(-2097152), 1'b1);
  endtask

  task automatic test_random_traffic(int unsigned tx_pct, int unsigned rx_pct,
                                     int per_setting);
    coef_t hp_bw;
    coef_t lp_bw;
    coef_t hp_c;
    coef_t lp_c;
    hp_bw = butterworth(300.0, 1'b1);
    lp_bw = butterworth(3000.0, 1'b0);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int setting = 0; setting < 5; setting++) begin
      wait_idle();
      case (setting)
        0: configure(1'b1, 1'b1, hp_bw, lp_bw);
        1: configure(1'b1, 1'b0, hp_bw, lp_bw);
        2: configure(1'b0, 1'b1, hp_bw, lp_bw);
        3: begin
          hp_c = '{b0: COEF_BITS'($urandom), a1: COEF_BITS'($urandom),
                   a2: COEF_BITS'($urandom)};
          lp_c = '{b0: COEF_BITS'($urandom), a1: COEF_BITS'($urandom),
                   a2: COEF_BITS'($urandom)};
          configure(1'($urandom_range(1)), 1'($urandom_range(1)), hp_c, lp_c);
        end
        default: begin
          hp_c = '{b0: 24'h7FFFFF, a1: 24'h800000, a2: 24'h7FFFFF};
          lp_c = '{b0: 24'h800000, a1: 24'h7FFFFF, a2: 24'h800000};
          configure(1'b1, 1'b1, hp_c, lp_c);
        end
      endcase
      repeat (per_setting) send_sample(random_sample(), $urandom_range(15) == 0);
    end
  endtask

  // receiver holds off while the sender keeps offering; input must back up
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_idle();
    configure(1'b1, 1'b1, butterworth(300.0, 1'b1), butterworth(3000.0, 1'b0));
    fork
      begin
        rx_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      repeat (48) send_sample(random_sample(), $urandom_range(7) == 0);
    join
  endtask

  initial begin
    hp_on   = 1'b0;
    lp_on   = 1'b0;
    hp_coef = '{b0: B0_RESET, a1: '0, a2: '0};
    lp_coef = '{b0: B0_RESET, a1: '0, a2: '0};
    for (int s = 0; s < 2; s++) begin
      past_x[s][0] = '0;
      past_x[s][1] = '0;
      past_y[s][0] = '0;
      past_y[s][1] = '0;
    end
    samples_if.valid         = 1'b0;
    samples_if.sample_in     = '0;
    samples_if.last_in_block = 1'b0;
    cfg_if.valid             = 1'b0;
    cfg_if.reg_index         = REG_HP_ENABLE;
    cfg_if.wr_data           = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bypass_extremes();
    test_section_extremes();
    test_random_traffic(36, 78, 90);
    test_random_traffic(78, 36, 90);
    test_random_traffic(0, 0, 90);
    test_output_stall();
    wait_idle();

    $display("%0d samples sent, %0d words checked, %0d register writes",
             n_sent, n_checked, n_writes);
    $display("bypass, single and cascaded sections, %0d clipped section outputs",
             n_clipped);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### cascaded_highpass_lowpass_biquad_top.f
rtl/chbq_pkg.sv
rtl/chbq_if.sv
rtl/chbq_section.sv
rtl/cascaded_highpass_lowpass_biquad_top.sv
tb/tb.sv
